>>> rtl/sncs_pkg.sv
package sncs_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int TOTAL_BYTES  = 2097152;
    localparam int CHIP_SECTORS = TOTAL_BYTES / SECTOR_BYTES;

    localparam int QUEUE_DEPTH  = 4;
    localparam int NSTEPS       = 19;

    // input kinds
    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_WDATA = 2'd2;

    // operations
    localparam logic [1:0] OP_READ_ID = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;
    localparam logic [1:0] OP_ERASE   = 2'd3;

    // result actions
    localparam logic [2:0] ACT_SEL   = 3'd0;
    localparam logic [2:0] ACT_REL   = 3'd1;
    localparam logic [2:0] ACT_SEND  = 3'd2;
    localparam logic [2:0] ACT_RDOUT = 3'd3;
    localparam logic [2:0] ACT_NEED  = 3'd4;
    localparam logic [2:0] ACT_DONE  = 3'd5;
    localparam logic [2:0] ACT_ID    = 3'd6;

    // flash opcodes
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_RDSR   = 8'h05;
    localparam logic [7:0] CMD_RDID   = 8'h9F;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_PP     = 8'h02;
    localparam logic [7:0] CMD_CE     = 8'h60;
    localparam logic [7:0] CMD_SE     = 8'h20;
    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    // step slots, emitted lowest first
    localparam int ST_REL0   = 0;
    localparam int ST_RDOUT  = 1;
    localparam int ST_SENDD  = 2;
    localparam int ST_WE_SEL = 3;
    localparam int ST_WE_CMD = 4;
    localparam int ST_WE_REL = 5;
    localparam int ST_SEL    = 6;
    localparam int ST_CMD    = 7;
    localparam int ST_A2     = 8;
    localparam int ST_A1     = 9;
    localparam int ST_A0     = 10;
    localparam int ST_FFW    = 11;
    localparam int ST_NEED   = 12;
    localparam int ST_REL    = 13;
    localparam int ST_P_SEL  = 14;
    localparam int ST_P_CMD  = 15;
    localparam int ST_P_FFW  = 16;
    localparam int ST_DONE   = 17;
    localparam int ST_ID     = 18;

    typedef logic [NSTEPS-1:0] step_mask_t;

    typedef struct packed {
        step_mask_t  mask;
        logic [7:0]  cmd;
        logic [23:0] addr;
        logic [7:0]  data;
        logic [15:0] dev;
    } entry_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [2:0] count;
    } queue_status_t;

endpackage

>>> rtl/sncs_front.sv
module sncs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          kind,
    input  logic [1:0]          operation,
    input  logic [23:0]         start_address,
    input  logic [15:0]         item_count,
    input  logic [7:0]          data_in,
    output logic                push,
    output sncs_pkg::entry_t    entry
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ID_MAN = 3'd1;
    localparam logic [2:0] PH_ID_HI  = 3'd2;
    localparam logic [2:0] PH_ID_LO  = 3'd3;
    localparam logic [2:0] PH_READ   = 3'd4;
    localparam logic [2:0] PH_WDATA  = 3'd5;
    localparam logic [2:0] PH_POLL   = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  op_reg, op_next;
    logic [23:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [8:0]  pbl_reg, pbl_next;
    logic        aligned_reg, aligned_next;
    logic [23:0] gather_reg, gather_next;

    sncs_pkg::step_mask_t m;
    logic [7:0]  cmd;
    logic [7:0]  dat;
    logic [15:0] dev;
    logic [23:0] ent_addr;
    logic        do_prog, do_sec;
    logic [15:0] rem_dec;
    logic [8:0]  pbl_dec;

    always_comb
    begin
        phase_next   = phase_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        pbl_next     = pbl_reg;
        aligned_next = aligned_reg;
        gather_next  = gather_reg;
        m            = '0;
        cmd          = 8'h00;
        dat          = 8'h00;
        dev          = 16'h0000;
        do_prog      = 1'b0;
        do_sec       = 1'b0;
        rem_dec      = rem_reg - 16'd1;
        pbl_dec      = pbl_reg - 9'd1;
        ent_addr     = addr_reg;

        if (accept)
        begin
            case (kind)
                sncs_pkg::KIND_REQ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        op_next   = operation;
                        addr_next = start_address;
                        rem_next  = item_count;
                        case (operation)
                            sncs_pkg::OP_READ_ID:
                            begin
                                gather_next = '0;
                                m[sncs_pkg::ST_SEL] = 1'b1;
                                m[sncs_pkg::ST_CMD] = 1'b1;
                                m[sncs_pkg::ST_FFW] = 1'b1;
                                cmd = sncs_pkg::CMD_RDID;
                                phase_next = PH_ID_MAN;
                            end
                            sncs_pkg::OP_READ:
                            begin
                                m[sncs_pkg::ST_SEL] = 1'b1;
                                m[sncs_pkg::ST_CMD] = 1'b1;
                                m[sncs_pkg::ST_A2]  = 1'b1;
                                m[sncs_pkg::ST_A1]  = 1'b1;
                                m[sncs_pkg::ST_A0]  = 1'b1;
                                cmd = sncs_pkg::CMD_READ;
                                if (item_count != 16'd0)
                                begin
                                    m[sncs_pkg::ST_FFW] = 1'b1;
                                    phase_next = PH_READ;
                                end
                                else
                                begin
                                    m[sncs_pkg::ST_REL]  = 1'b1;
                                    m[sncs_pkg::ST_DONE] = 1'b1;
                                end
                            end
                            sncs_pkg::OP_WRITE:
                            begin
                                aligned_next = ((start_address &
                                    24'(sncs_pkg::PAGE_BYTES - 1)) == 24'd0);
                                if (item_count == 16'd0)
                                    m[sncs_pkg::ST_DONE] = 1'b1;
                                else
                                    do_prog = 1'b1;
                            end
                            default:
                            begin
                                if (start_address == 24'd0 &&
                                    item_count == 16'(sncs_pkg::CHIP_SECTORS))
                                begin
                                    rem_next = 16'd0;
                                    m[sncs_pkg::ST_WE_SEL] = 1'b1;
                                    m[sncs_pkg::ST_WE_CMD] = 1'b1;
                                    m[sncs_pkg::ST_WE_REL] = 1'b1;
                                    m[sncs_pkg::ST_SEL]    = 1'b1;
                                    m[sncs_pkg::ST_CMD]    = 1'b1;
                                    m[sncs_pkg::ST_REL]    = 1'b1;
                                    m[sncs_pkg::ST_P_SEL]  = 1'b1;
                                    m[sncs_pkg::ST_P_CMD]  = 1'b1;
                                    m[sncs_pkg::ST_P_FFW]  = 1'b1;
                                    cmd = sncs_pkg::CMD_CE;
                                    phase_next = PH_POLL;
                                end
                                else if (item_count == 16'd0)
                                    m[sncs_pkg::ST_DONE] = 1'b1;
                                else
                                    do_sec = 1'b1;
                            end
                        endcase
                    end
                end
                sncs_pkg::KIND_REPLY:
                begin
                    case (phase_reg)
                        PH_ID_MAN:
                        begin
                            gather_next[23:16] = data_in;
                            m[sncs_pkg::ST_FFW] = 1'b1;
                            phase_next = PH_ID_HI;
                        end
                        PH_ID_HI:
                        begin
                            gather_next[15:8] = data_in;
                            m[sncs_pkg::ST_FFW] = 1'b1;
                            phase_next = PH_ID_LO;
                        end
                        PH_ID_LO:
                        begin
                            gather_next[7:0] = data_in;
                            m[sncs_pkg::ST_REL] = 1'b1;
                            m[sncs_pkg::ST_ID]  = 1'b1;
                            dat = gather_reg[23:16];
                            dev = {gather_reg[15:8], data_in};
                            phase_next = PH_IDLE;
                        end
                        PH_READ:
                        begin
                            m[sncs_pkg::ST_RDOUT] = 1'b1;
                            dat = data_in;
                            rem_next  = rem_dec;
                            addr_next = addr_reg + 24'd1;
                            if (rem_dec != 16'd0)
                                m[sncs_pkg::ST_FFW] = 1'b1;
                            else
                            begin
                                m[sncs_pkg::ST_REL]  = 1'b1;
                                m[sncs_pkg::ST_DONE] = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_POLL:
                        begin
                            m[sncs_pkg::ST_REL0] = 1'b1;
                            if (data_in[0])
                            begin
                                m[sncs_pkg::ST_P_SEL] = 1'b1;
                                m[sncs_pkg::ST_P_CMD] = 1'b1;
                                m[sncs_pkg::ST_P_FFW] = 1'b1;
                            end
                            else if (rem_reg == 16'd0)
                            begin
                                m[sncs_pkg::ST_DONE] = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else if (op_reg == sncs_pkg::OP_WRITE)
                                do_prog = 1'b1;
                            else
                                do_sec = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                sncs_pkg::KIND_WDATA:
                begin
                    if (phase_reg == PH_WDATA)
                    begin
                        m[sncs_pkg::ST_SENDD] = 1'b1;
                        dat = data_in;
                        addr_next = addr_reg + 24'd1;
                        rem_next  = rem_dec;
                        pbl_next  = pbl_dec;
                        if (pbl_dec != 9'd0 && rem_dec != 16'd0)
                            m[sncs_pkg::ST_NEED] = 1'b1;
                        else
                        begin
                            m[sncs_pkg::ST_REL]   = 1'b1;
                            m[sncs_pkg::ST_P_SEL] = 1'b1;
                            m[sncs_pkg::ST_P_CMD] = 1'b1;
                            m[sncs_pkg::ST_P_FFW] = 1'b1;
                            phase_next = PH_POLL;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // address bytes go out before any sector advance
        ent_addr = addr_next;

        if (do_prog)
        begin
            if (aligned_next)
                pbl_next = (rem_next > 16'(sncs_pkg::PAGE_BYTES)) ?
                           9'(sncs_pkg::PAGE_BYTES) : rem_next[8:0];
            else
                pbl_next = 9'd1;
            m[sncs_pkg::ST_WE_SEL] = 1'b1;
            m[sncs_pkg::ST_WE_CMD] = 1'b1;
            m[sncs_pkg::ST_WE_REL] = 1'b1;
            m[sncs_pkg::ST_SEL]    = 1'b1;
            m[sncs_pkg::ST_CMD]    = 1'b1;
            m[sncs_pkg::ST_A2]     = 1'b1;
            m[sncs_pkg::ST_A1]     = 1'b1;
            m[sncs_pkg::ST_A0]     = 1'b1;
            m[sncs_pkg::ST_NEED]   = 1'b1;
            cmd = sncs_pkg::CMD_PP;
            phase_next = PH_WDATA;
        end

        if (do_sec)
        begin
            m[sncs_pkg::ST_WE_SEL] = 1'b1;
            m[sncs_pkg::ST_WE_CMD] = 1'b1;
            m[sncs_pkg::ST_WE_REL] = 1'b1;
            m[sncs_pkg::ST_SEL]    = 1'b1;
            m[sncs_pkg::ST_CMD]    = 1'b1;
            m[sncs_pkg::ST_A2]     = 1'b1;
            m[sncs_pkg::ST_A1]     = 1'b1;
            m[sncs_pkg::ST_A0]     = 1'b1;
            m[sncs_pkg::ST_REL]    = 1'b1;
            m[sncs_pkg::ST_P_SEL]  = 1'b1;
            m[sncs_pkg::ST_P_CMD]  = 1'b1;
            m[sncs_pkg::ST_P_FFW]  = 1'b1;
            cmd = sncs_pkg::CMD_SE;
            rem_next  = rem_next - 16'd1;
            addr_next = addr_next + 24'(sncs_pkg::SECTOR_BYTES);
            phase_next = PH_POLL;
        end
    end

    assign push       = accept && (m != '0);
    assign entry.mask = m;
    assign entry.cmd  = cmd;
    assign entry.addr = ent_addr;
    assign entry.data = dat;
    assign entry.dev  = dev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            op_reg      <= '0;
            addr_reg    <= '0;
            rem_reg     <= '0;
            pbl_reg     <= '0;
            aligned_reg <= 1'b0;
            gather_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            op_reg      <= op_next;
            addr_reg    <= addr_next;
            rem_reg     <= rem_next;
            pbl_reg     <= pbl_next;
            aligned_reg <= aligned_next;
            gather_reg  <= gather_next;
        end
    end

endmodule

>>> rtl/sncs_queue.sv
module sncs_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sncs_pkg::entry_t        wr_entry,
    input  logic                    pop,
    output sncs_pkg::entry_t        head,
    output sncs_pkg::queue_status_t status
);

    localparam int AW = $clog2(sncs_pkg::QUEUE_DEPTH);

    sncs_pkg::entry_t mem [sncs_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign head          = mem[rp_reg];
    assign status.count  = 3'(cnt_reg);
    assign status.full   = (cnt_reg == (AW+1)'(sncs_pkg::QUEUE_DEPTH));
    assign status.empty  = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

>>> rtl/sncs_back.sv
module sncs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sncs_pkg::entry_t        head,
    input  logic                    head_valid,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              action,
    output logic [7:0]              send_value,
    output logic                    reply_wanted,
    output logic [15:0]             device_code,
    output logic                    last_of_run
);

    sncs_pkg::step_mask_t done_reg;
    sncs_pkg::step_mask_t pending, pick;
    logic [4:0]  idx;
    logic        last;
    logic        advance;
    logic [2:0]  act;
    logic [7:0]  val;
    logic        want;
    logic [15:0] dv;

    logic        valid_reg;
    logic [2:0]  act_reg;
    logic [7:0]  val_reg;
    logic        want_reg;
    logic [15:0] dev_reg;
    logic        last_reg;

    assign pending = head.mask & ~done_reg;
    assign pick    = pending & (~pending + 1'b1);
    assign last    = ((pending & ~pick) == '0);
    assign advance = head_valid && (!valid_reg || out_ready);
    assign pop     = advance && last;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < sncs_pkg::NSTEPS; i++)
        begin
            if (pick[i])
                idx = 5'(i);
        end
    end

    always_comb
    begin
        act  = sncs_pkg::ACT_SEND;
        val  = 8'h00;
        want = 1'b0;
        dv   = 16'h0000;
        case (idx)
            5'(sncs_pkg::ST_REL0), 5'(sncs_pkg::ST_WE_REL), 5'(sncs_pkg::ST_REL):
                act = sncs_pkg::ACT_REL;
            5'(sncs_pkg::ST_WE_SEL), 5'(sncs_pkg::ST_SEL), 5'(sncs_pkg::ST_P_SEL):
                act = sncs_pkg::ACT_SEL;
            5'(sncs_pkg::ST_RDOUT):
            begin
                act = sncs_pkg::ACT_RDOUT;
                val = head.data;
            end
            5'(sncs_pkg::ST_SENDD):
                val = head.data;
            5'(sncs_pkg::ST_WE_CMD):
                val = sncs_pkg::CMD_WREN;
            5'(sncs_pkg::ST_CMD):
                val = head.cmd;
            5'(sncs_pkg::ST_A2):
                val = head.addr[23:16];
            5'(sncs_pkg::ST_A1):
                val = head.addr[15:8];
            5'(sncs_pkg::ST_A0):
                val = head.addr[7:0];
            5'(sncs_pkg::ST_FFW), 5'(sncs_pkg::ST_P_FFW):
            begin
                val  = sncs_pkg::DUMMY_BYTE;
                want = 1'b1;
            end
            5'(sncs_pkg::ST_NEED):
                act = sncs_pkg::ACT_NEED;
            5'(sncs_pkg::ST_P_CMD):
                val = sncs_pkg::CMD_RDSR;
            5'(sncs_pkg::ST_DONE):
                act = sncs_pkg::ACT_DONE;
            5'(sncs_pkg::ST_ID):
            begin
                act = sncs_pkg::ACT_ID;
                val = head.data;
                dv  = head.dev;
            end
            default:
                act = sncs_pkg::ACT_SEND;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
            done_reg  <= last ? '0 : (done_reg | pick);
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act_reg  <= act;
            val_reg  <= val;
            want_reg <= want;
            dev_reg  <= dv;
            last_reg <= last;
        end
    end

    assign out_valid    = valid_reg;
    assign action       = act_reg;
    assign send_value   = val_reg;
    assign reply_wanted = want_reg;
    assign device_code  = dev_reg;
    assign last_of_run  = last_reg;

endmodule

>>> rtl/spi_nor_flash_command_sequencer.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser kind, tdata request/byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata result, tlast last of run
//
// An input item is taken whenever the four-entry queue has room;
// the front updates all sequencing state in the cycle it is taken.
// The back emits one result a cycle from the queue head unless the output
// stalls, so an item yields 0 to 13 results, one per step its entry carries.
// Reset clears the phase and queue; no clearing pass. Either side may stall.
module spi_nor_flash_command_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [25:2] start_address, [41:26] item_count, [49:42] data_in
    input  logic [55:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] action, [10:3] send_value, [11] reply_wanted, [27:12] device_code
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    sncs_pkg::entry_t        wr_entry, head;
    sncs_pkg::queue_status_t qs;
    logic push, pop, accept;
    logic [2:0]  action;
    logic [7:0]  send_value;
    logic        reply_wanted;
    logic [15:0] device_code;

    assign s_axis_tready = !qs.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sncs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (s_axis_tuser),
        .operation     (s_axis_tdata[1:0]),
        .start_address (s_axis_tdata[25:2]),
        .item_count    (s_axis_tdata[41:26]),
        .data_in       (s_axis_tdata[49:42]),
        .push          (push),
        .entry         (wr_entry)
    );

    sncs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .status   (qs)
    );

    sncs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (!qs.empty),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .action       (action),
        .send_value   (send_value),
        .reply_wanted (reply_wanted),
        .device_code  (device_code),
        .last_of_run  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, device_code, reply_wanted, send_value, action};

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qs.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qs.empty)
        else $error("queue popped while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (qs.count == $past(qs.count) + 3'd1))
        else $error("queue count did not follow a push");

endmodule
